// ===== hdl/qlte_pkg.sv =====
// shared types and constants for the q-learning table engine
`timescale 1ns / 1ps

package qlte_pkg;

  // operation codes on the request func field
  localparam logic FUNC_CHOOSE = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_EPSILON  = 2'd0;
  localparam logic [1:0] CFG_ALPHA    = 2'd1;
  localparam logic [1:0] CFG_GAMMA    = 2'd2;

  localparam logic [6:0]  EPSILON_RESET = 7'd20;
  localparam logic [15:0] ALPHA_RESET   = 16'd6554;
  localparam logic [15:0] GAMMA_RESET   = 16'd58982;

  typedef struct packed {
    logic               func;
    logic [7:0]         state_key;
    logic [2:0]         action;
    logic signed [31:0] reward;
    logic [7:0]         next_state_key;
    logic [6:0]         random_draw;
    logic [2:0]         random_action;
  } req_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic               explored;
    logic signed [31:0] new_value;
  } resp_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_QREAD,
    ST_MUL1,
    ST_TARGET,
    ST_MUL2,
    ST_SUM,
    ST_WRITE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic clear_we;
    logic scan_step;
    logic mark_seen;
    logic q_read_sa;
    logic mul1;
    logic target;
    logic mul2;
    logic sum;
    logic write_q;
    logic load_res;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_update;
    logic in_act_ok;
    logic item_update;
    logic scan_last;
    logic clr_last;
    logic res_free;
  } sts_t;

endpackage

// ===== hdl/qlte_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module qlte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1280
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== hdl/qlte_ctrl.sv =====
// sequencing state machine for the q-learning table engine
`timescale 1ns / 1ps

module qlte_ctrl
  import qlte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          // update with an out of range action skips straight to the result
          if (!sts.in_update || sts.in_act_ok) state_next = ST_SCAN;
          else state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) state_next = sts.item_update ? ST_QREAD : ST_DRAIN;
      end
      ST_DRAIN:  state_next = ST_DONE;
      ST_QREAD:  state_next = ST_MUL1;
      ST_MUL1:   state_next = ST_TARGET;
      ST_TARGET: state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_SUM;
      ST_SUM:    state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_DONE;
      ST_DONE: begin
        if (sts.res_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    req_stall = 1'b1;
    case (state)
      ST_CLEAR:  ctl.clear_we = 1'b1;
      ST_IDLE: begin
        req_stall = 1'b0;
        ctl.load_item = req_valid;
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        ctl.mark_seen = sts.item_update;
      end
      ST_DRAIN:  ctl = '0;
      ST_QREAD:  ctl.q_read_sa = 1'b1;
      ST_MUL1:   ctl.mul1 = 1'b1;
      ST_TARGET: ctl.target = 1'b1;
      ST_MUL2:   ctl.mul2 = 1'b1;
      ST_SUM:    ctl.sum = 1'b1;
      ST_WRITE:  ctl.write_q = 1'b1;
      ST_DONE:   ctl.load_res = sts.res_free;
      default:   ctl = '0;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted but block not busy next cycle");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && sts.res_free) |=> state == ST_IDLE)
    else $error("result loaded but controller did not return to idle");

  a_update_scan_to_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && sts.scan_last && sts.item_update) |=> state == ST_QREAD)
    else $error("update scan did not proceed to value read");

endmodule

// ===== hdl/qlte_datapath.sv =====
// table memories, row scan, fixed-point update arithmetic and result register
`timescale 1ns / 1ps

module qlte_datapath
  import qlte_pkg::*;
#(
  parameter int STATE_KEY_BITS = 8,
  parameter int ACTION_COUNT   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  req_t        req,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        resp_valid,
  input  logic        resp_stall,
  output resp_t       resp
);

  localparam int STATES  = 1 << STATE_KEY_BITS;
  localparam int ENTRIES = STATES * ACTION_COUNT;
  localparam int AW      = $clog2(ENTRIES);
  localparam int IW      = $clog2(ACTION_COUNT);

  function automatic logic signed [31:0] sat_q(input logic signed [50:0] v);
    if (v > 51'sd2147483647) return 32'sh7fffffff;
    else if (v < -51'sd2147483648) return 32'sh80000000;
    else return 32'(v);
  endfunction

  // configuration
  logic [6:0]  epsilon;
  logic [15:0] alpha;
  logic [15:0] gamma;

  // item and scan state
  req_t                      item;
  logic [STATE_KEY_BITS+7:0] s_ext;
  logic [STATE_KEY_BITS+7:0] ns_ext;
  logic [STATE_KEY_BITS-1:0] s_key;
  logic [STATE_KEY_BITS-1:0] ns_key;
  logic [STATE_KEY_BITS-1:0] scan_key;
  logic                      item_upd;
  logic [IW-1:0]             cnt;
  logic [AW-1:0]             clr_addr;
  logic                      rd_pend;
  logic [IW-1:0]             rd_idx;
  logic signed [31:0]        best_val;
  logic [IW-1:0]             best_idx;

  // memory ports
  logic          q_we;
  logic [AW-1:0] q_waddr;
  logic [31:0]   q_wdata;
  logic [AW-1:0] q_raddr;
  logic [31:0]   q_rdata;
  logic [AW-1:0] scan_addr;
  logic [AW-1:0] sa_addr;
  logic                      seen_we;
  logic [STATE_KEY_BITS-1:0] seen_waddr;
  logic                      seen_wdata;
  logic                      seen_rd;

  // arithmetic
  logic signed [31:0] q_reg;
  logic signed [48:0] prod1;
  logic signed [48:0] p1r;
  logic signed [33:0] tsum;
  logic signed [31:0] target_reg;
  logic [16:0]        inv_alpha;
  logic signed [49:0] pa;
  logic signed [48:0] pb;
  logic signed [50:0] blend;
  logic signed [50:0] br;
  logic signed [31:0] nv;
  logic signed [31:0] res_value;

  // result
  logic  explore;
  logic [2:0] pick_r;
  resp_t res_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      epsilon <= EPSILON_RESET;
      alpha   <= ALPHA_RESET;
      gamma   <= GAMMA_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EPSILON: epsilon <= cfg_data[6:0];
        CFG_ALPHA:   alpha   <= cfg_data;
        CFG_GAMMA:   gamma   <= cfg_data;
        default:     epsilon <= epsilon;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) item <= req;
  end

  // low key bits select the state; zero extended for wide key parameters
  assign s_ext    = {{STATE_KEY_BITS{1'b0}}, item.state_key};
  assign ns_ext   = {{STATE_KEY_BITS{1'b0}}, item.next_state_key};
  assign s_key    = s_ext[STATE_KEY_BITS-1:0];
  assign ns_key   = ns_ext[STATE_KEY_BITS-1:0];
  assign item_upd = (item.func == FUNC_UPDATE);
  assign scan_key = item_upd ? ns_key : s_key;

  assign scan_addr = AW'(scan_key) * AW'(ACTION_COUNT) + AW'(cnt);
  assign sa_addr   = AW'(s_key) * AW'(ACTION_COUNT) + AW'(item.action);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      if (ctl.load_item) cnt <= '0;
      else if (ctl.scan_step) cnt <= cnt + IW'(1);
      if (ctl.clear_we) clr_addr <= clr_addr + AW'(1);
      rd_pend <= ctl.scan_step;
    end
  end

  // q table
  assign q_we    = ctl.clear_we || ctl.write_q;
  assign q_waddr = ctl.clear_we ? clr_addr : sa_addr;
  assign q_wdata = ctl.clear_we ? '0 : nv;
  assign q_raddr = ctl.q_read_sa ? sa_addr : scan_addr;

  qlte_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_qram (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_addr (q_raddr),
    .rd_data (q_rdata)
  );

  // seen bits: current state on the first scan beat, next state on the second
  assign seen_we = (ctl.clear_we && clr_addr < AW'(STATES))
                || (ctl.mark_seen && cnt <= IW'(1));
  assign seen_waddr = ctl.clear_we ? clr_addr[STATE_KEY_BITS-1:0]
                    : ((cnt == '0) ? s_key : ns_key);
  assign seen_wdata = !ctl.clear_we;

  qlte_ram #(.WIDTH(1), .DEPTH(STATES)) u_seen (
    .clk     (clk),
    .wr_en   (seen_we),
    .wr_addr (seen_waddr),
    .wr_data (seen_wdata),
    .rd_addr (s_key),
    .rd_data (seen_rd)
  );

  // running max over the row, first index wins on ties
  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    if (rd_pend && (rd_idx == '0 || $signed(q_rdata) > best_val)) begin
      best_val <= $signed(q_rdata);
      best_idx <= rd_idx;
    end
  end

  assign p1r       = (prod1 + 49'sd32768) >>> 16;
  assign tsum      = 34'(item.reward) + 34'(p1r);
  assign inv_alpha = 17'h10000 - {1'b0, alpha};
  assign br        = (blend + 51'sd32768) >>> 16;
  assign nv        = sat_q(br);

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      q_reg <= $signed(q_rdata);
      prod1 <= $signed({1'b0, gamma}) * best_val;
    end
    if (ctl.target) target_reg <= sat_q(51'(tsum));
    if (ctl.mul2) begin
      pa <= $signed({1'b0, inv_alpha}) * q_reg;
      pb <= $signed({1'b0, alpha}) * target_reg;
    end
    if (ctl.sum) blend <= 51'(pa) + 51'(pb);
    if (ctl.load_item) res_value <= '0;
    else if (ctl.write_q) res_value <= nv;
  end

  assign explore = (item.random_draw < epsilon) || !seen_rd;
  assign pick_r  = (32'(item.random_action) < ACTION_COUNT)
                 ? item.random_action : 3'(ACTION_COUNT - 1);

  always_comb begin
    res_next = '0;
    if (item_upd) begin
      res_next.new_value = res_value;
    end else begin
      res_next.chosen_action = explore ? pick_r : 3'(best_idx);
      res_next.explored      = explore;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (ctl.load_res) begin
      resp_valid <= 1'b1;
    end else if (!resp_stall) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_res) resp <= res_next;
  end

  assign sts.in_update   = (req.func == FUNC_UPDATE);
  assign sts.in_act_ok   = (32'(req.action) < ACTION_COUNT);
  assign sts.item_update = item_upd;
  assign sts.scan_last   = (cnt == IW'(ACTION_COUNT - 1));
  assign sts.clr_last    = (clr_addr == AW'(ENTRIES - 1));
  assign sts.res_free    = !resp_valid || !resp_stall;

  a_explore_no_value: assert property (@(posedge clk) disable iff (rst)
    (resp_valid && resp.explored) |-> resp.new_value == '0)
    else $error("explored choose result carries a value");

  a_result_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(resp_valid) |-> $past(ctl.load_res))
    else $error("result valid rose without a load");

endmodule

// ===== hdl/q_learning_table_engine.sv =====
// top level of the tabular q-learning engine with epsilon-greedy choice
`timescale 1ns / 1ps

// After reset the block sweeps the value table and seen bits to zero, one entry
// per cycle, over all STATES*ACTION_COUNT entries (1280 at the default parameters);
// requests stall during the sweep while configuration writes are taken. Items
// are handled one at a time. A choose beat scans its row and then returns the
// result; an update beat scans the next-state row, then reads its own entry:
// the value table has one read port, so a row is scanned one entry per cycle,
// and an update then runs a registered chain of the discount multiply, target
// saturation, the two blend multiplies, the sum and the rounding write. The
// result sits in an output register, so a stalled result only holds the block
// once the next result is ready.
module q_learning_table_engine
  import qlte_pkg::*;
#(
  parameter int STATE_KEY_BITS = 8,
  parameter int ACTION_COUNT   = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        resp_valid,
  input  logic        resp_stall,
  output resp_t       resp
);

  ctl_t ctl;
  sts_t sts;

  qlte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  qlte_datapath #(
    .STATE_KEY_BITS (STATE_KEY_BITS),
    .ACTION_COUNT   (ACTION_COUNT)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctl        (ctl),
    .sts        (sts),
    .resp_valid (resp_valid),
    .resp_stall (resp_stall),
    .resp       (resp)
  );

endmodule
